/* src/spwm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spwm_pkg
// Shared constants and types of the sine PWM compare generator.
// ----------------------------------------------------------------------------
package spwm_pkg;

    localparam int SINE_STEPS_DEF = 832;
    localparam int Q_DEPTH_DEF    = 4;

    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOD      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd2;

    localparam logic [CFG_W-1:0] PERIOD_RESET   = 16'd1000;
    localparam logic [CFG_W-1:0] MOD_RESET      = 16'd32768;
    localparam logic [CFG_W-1:0] INTERVAL_RESET = 16'd50;
    localparam logic [CFG_W-1:0] MOD_FULL       = 16'd32768;

    localparam int CMP_W   = 16;
    localparam int PHOUT_W = 10;

    typedef struct packed {
        logic [CFG_W-1:0] timer_period;
        logic [CFG_W-1:0] mod_index;
        logic [CFG_W-1:0] adc_interval;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

/* src/spwm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spwm_front
// Accepts tick transactions, steps the phase and ADC sample counters and
// pushes one job per tick into the queue.
// ----------------------------------------------------------------------------
module spwm_front import spwm_pkg::*; #(
    parameter int SINE_STEPS = SINE_STEPS_DEF,
    parameter int PW         = $clog2(SINE_STEPS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_tick,
    output logic          o_ready,
    input  t_cfg          i_cfg,
    input  t_q_stat       i_q_stat,
    output logic          o_push,
    output logic [PW:0]   o_entry      // phase index, then adc trigger on top
);

    logic [PW-1:0]    r_phase;
    logic [PW-1:0]    n_phase;
    logic [CFG_W-1:0] r_sample;
    logic [CFG_W-1:0] n_sample;
    logic             w_trig;
    logic             w_accept;

    assign o_ready  = !i_q_stat.full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept && i_tick;

    always_comb begin
        if (r_phase >= PW'(SINE_STEPS)) begin
            n_phase = '0;
        end else begin
            n_phase = r_phase + PW'(1);
        end
        if (r_sample < i_cfg.adc_interval) begin
            n_sample = r_sample + CFG_W'(1);
            w_trig   = 1'b0;
        end else begin
            n_sample = '0;
            w_trig   = 1'b1;
        end
    end

    assign o_entry = {w_trig, n_phase};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_sample <= '0;
        end else if (o_push) begin
            r_phase  <= n_phase;
            r_sample <= n_sample;
        end
    end

endmodule

/* src/spwm_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spwm_queue
// Small register queue that decouples the tick front end from the
// compare arithmetic.
// ----------------------------------------------------------------------------
module spwm_queue import spwm_pkg::*; #(
    parameter int W     = 11,
    parameter int DEPTH = Q_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output t_q_stat      o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [0:DEPTH-1];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* src/spwm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spwm_back
// Sine ROM lookup and compare arithmetic: F = 2^30 + m*s, then
// compare = (period * F) >> 31, three stages ending in the output register.
// ----------------------------------------------------------------------------
module spwm_back import spwm_pkg::*; #(
    parameter int SINE_STEPS = SINE_STEPS_DEF,
    parameter int PW         = $clog2(SINE_STEPS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_q_stat            i_q_stat,
    input  logic [PW:0]        i_entry,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [CMP_W-1:0]   o_compare,
    output logic [PHOUT_W-1:0] o_phase,
    output logic               o_trig
);

    localparam real PI_HALF = 1.5707963267948966;

    logic signed [15:0] w_rom [0:SINE_STEPS];

    for (genvar gi = 0; gi <= SINE_STEPS; gi++) begin : g_rom
        localparam int  I4   = 4 * gi;
        localparam int  QUAD = (I4 / SINE_STEPS) % 4;
        localparam int  R0   = I4 % SINE_STEPS;
        localparam int  R    = (QUAD % 2 == 1) ? (SINE_STEPS - R0) : R0;
        localparam real X    = PI_HALF * R / SINE_STEPS;
        localparam int  MAG  = (3 * R == SINE_STEPS) ? 16384 :
                               $rtoi(32767.0 * $sin(X) + 0.5);
        localparam int  VAL  = (QUAD >= 2) ? -MAG : MAG;
        assign w_rom[gi] = 16'(VAL);
    end

    logic                w_adv;
    logic                r_v1;
    logic                r_v2;
    logic                r_out_valid;
    logic signed [15:0]  r_sine;
    logic [PW-1:0]       r_ph1;
    logic [PW-1:0]       r_ph2;
    logic [PW-1:0]       r_ph3;
    logic                r_tr1;
    logic                r_tr2;
    logic                r_tr3;
    logic [30:0]         r_f;
    logic [CMP_W-1:0]    r_cmp;
    logic [CFG_W-1:0]    w_m;
    logic signed [32:0]  w_ms;
    logic signed [32:0]  w_f;
    logic [46:0]         w_pf;
    logic [PW+PHOUT_W-1:0] w_ph_ext;

    assign w_adv = !r_out_valid || i_ready;
    assign o_pop = w_adv && !i_q_stat.empty;

    assign w_m  = (i_cfg.mod_index > MOD_FULL) ? MOD_FULL : i_cfg.mod_index;
    assign w_ms = $signed({1'b0, w_m}) * r_sine;
    assign w_f  = w_ms + 33'sd1073741824;
    assign w_pf = 47'(i_cfg.timer_period) * 47'(r_f);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sine <= w_rom[i_entry[PW-1:0]];
            r_ph1  <= i_entry[PW-1:0];
            r_tr1  <= i_entry[PW];
            r_f    <= w_f[30:0];
            r_ph2  <= r_ph1;
            r_tr2  <= r_tr1;
            r_cmp  <= w_pf[46:31];
            r_ph3  <= r_ph2;
            r_tr3  <= r_tr2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_v1        <= o_pop;
            r_v2        <= r_v1;
            r_out_valid <= r_v2;
        end
    end

    assign w_ph_ext  = {{PHOUT_W{1'b0}}, r_ph3};
    assign o_valid   = r_out_valid;
    assign o_compare = r_cmp;
    assign o_phase   = w_ph_ext[PHOUT_W-1:0];
    assign o_trig    = r_tr3;

endmodule

/* src/sine_pwm_compare_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_pwm_compare_generator
// Sine PWM compare generator: one compare value per PWM period tick.
// ----------------------------------------------------------------------------
// Each tick transaction with tdata bit 0 set steps the phase through a sine
// table of SINE_STEPS+1 entries and yields one result transaction holding
// period*(0.5 + m*sin/2) truncated, the table entry used and an ADC trigger
// flag raised once every adc_interval+1 ticks; ticks with bit 0 clear are
// taken and dropped. The block sustains one tick per clock cycle while the
// queue is not full: only the phase and sample counters close a loop per
// tick. A tick accepted into the four-entry queue becomes a valid result as
// its job leaves the queue with its ROM read, then m*s, then period*F into
// the output register. The queue absorbs ticks while the output is stalled.
// The sine ROM is a constant table; no clearing pass follows reset.
// ----------------------------------------------------------------------------
module sine_pwm_compare_generator import spwm_pkg::*; #(
    parameter int SINE_STEPS = SINE_STEPS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,  // [0] period_tick
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata   // [15:0] compare_value,
                                                // [25:16] phase_index,
                                                // [26] adc_trigger
);

    localparam int PW = $clog2(SINE_STEPS + 1);

    t_cfg                r_cfg;
    t_q_stat             w_q_stat;
    logic                w_push;
    logic                w_pop;
    logic [PW:0]         w_entry_in;
    logic [PW:0]         w_entry_out;
    logic [CMP_W-1:0]    w_compare;
    logic [PHOUT_W-1:0]  w_phase;
    logic                w_trig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timer_period <= PERIOD_RESET;
            r_cfg.mod_index    <= MOD_RESET;
            r_cfg.adc_interval <= INTERVAL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PERIOD:   r_cfg.timer_period <= i_cfg_data;
                REG_MOD:      r_cfg.mod_index    <= i_cfg_data;
                REG_INTERVAL: r_cfg.adc_interval <= i_cfg_data;
                default:      r_cfg              <= r_cfg;
            endcase
        end
    end

    spwm_front #(
        .SINE_STEPS (SINE_STEPS),
        .PW         (PW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_tick   (s_axis_tdata[0]),
        .o_ready  (s_axis_tready),
        .i_cfg    (r_cfg),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_entry  (w_entry_in)
    );

    spwm_queue #(
        .W     (PW + 1),
        .DEPTH (Q_DEPTH_DEF)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_entry_in),
        .i_pop   (w_pop),
        .o_data  (w_entry_out),
        .o_stat  (w_q_stat)
    );

    spwm_back #(
        .SINE_STEPS (SINE_STEPS),
        .PW         (PW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_stat  (w_q_stat),
        .i_entry   (w_entry_out),
        .o_pop     (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_compare (w_compare),
        .o_phase   (w_phase),
        .o_trig    (w_trig)
    );

    assign m_axis_tdata = {5'b0, w_trig, w_phase, w_compare};

endmodule

/* src/spwm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spwm_checker
// Port-level checks of the sine PWM compare generator, bound to the top.
// ----------------------------------------------------------------------------
module spwm_checker import spwm_pkg::*; #(
    parameter int SINE_STEPS = SINE_STEPS_DEF
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [31:0]          m_axis_tdata
);

    localparam bit WIDE = (SINE_STEPS > 1023);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result transaction dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result data changed while stalled");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31:27] == 5'b0))
        else $error("padding bits of result not zero");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (WIDE || (32'(m_axis_tdata[25:16]) <= 32'(SINE_STEPS))))
        else $error("phase index beyond sine table");

endmodule

bind sine_pwm_compare_generator spwm_checker #(.SINE_STEPS(SINE_STEPS)) u_spwm_checker (.*);
